/* hdl/lookup2_byte_stream_hash_top_macros.svh */
// ----------------------------------------------------------------------------
// lookup2_byte_stream_hash_top_macros
// Assertion macros shared by the byte stream hash RTL.
// ----------------------------------------------------------------------------
`ifndef LOOKUP2_BYTE_STREAM_HASH_TOP_MACROS_SVH
`define LOOKUP2_BYTE_STREAM_HASH_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define L2BH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("l2bh: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define L2BH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("l2bh: next-cycle check failed");

`endif

/* hdl/l2bh_pkg.sv */
// ----------------------------------------------------------------------------
// l2bh_pkg
// Types, constants and the mix round shared by the byte stream hash.
// ----------------------------------------------------------------------------
package l2bh_pkg;

    localparam logic [31:0] INIT_AB     = 32'h9e3779b9;
    localparam logic [31:0] INIT_C      = 32'habcdef01;
    localparam int unsigned BLOCK_BYTES = 12;
    localparam logic [3:0]  BLOCK_LAST  = 4'(BLOCK_BYTES - 1);
    localparam int unsigned MIX_ROWS    = 9;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    localparam words_t INIT_WORDS = '{a: INIT_AB, b: INIT_AB, c: INIT_C};

    // sideband carried through a mix pipeline with its words
    typedef struct packed {
        logic   mix_en;  // apply the rounds; 0 passes words through untouched
        logic   fin;     // entry ends a key
        logic   both;    // block completed on the last byte: tail follows the mix
        words_t tail;    // added to the mixed or base words at the pipe exit
    } mix_ctl_t;

    // which word a round updates
    localparam logic [1:0] WORD_A = 2'd0;
    localparam logic [1:0] WORD_B = 2'd1;
    localparam logic [1:0] WORD_C = 2'd2;

    localparam logic [1:0] MIX_WORD [MIX_ROWS] = '{
        WORD_A, WORD_B, WORD_C, WORD_A, WORD_B, WORD_C, WORD_A, WORD_B, WORD_C
    };
    localparam logic [4:0] MIX_SHIFT [MIX_ROWS] = '{
        5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
    };

    // one round of the mix: x = (x - next - prev) ^ shifted(prev)
    function automatic words_t mix_row(input words_t w, input logic [3:0] row);
        words_t     r;
        logic [4:0] sh;
        r  = w;
        sh = MIX_SHIFT[row];
        case (MIX_WORD[row])
            WORD_A: begin
                r.a = (w.a - w.b - w.c) ^ (w.c >> sh);
            end
            WORD_B: begin
                r.b = (w.b - w.c - w.a) ^ (w.a << sh);
            end
            default: begin
                r.c = (w.c - w.a - w.b) ^ (w.b >> sh);
            end
        endcase
        return r;
    endfunction

endpackage

/* hdl/l2bh_mix_pipe.sv */
// ----------------------------------------------------------------------------
// l2bh_mix_pipe
// Nine-stage mix pipeline, one round per stage, with a pass-through mode.
// ----------------------------------------------------------------------------
module l2bh_mix_pipe (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  l2bh_pkg::words_t   in_words,
    input  l2bh_pkg::mix_ctl_t in_ctl,
    output logic               out_valid,
    output l2bh_pkg::words_t   out_words,
    output l2bh_pkg::mix_ctl_t out_ctl
);

    localparam int unsigned ROWS = l2bh_pkg::MIX_ROWS;

    logic [ROWS-1:0]    valid_reg;
    l2bh_pkg::words_t   words_reg [ROWS];
    l2bh_pkg::mix_ctl_t ctl_reg   [ROWS];

    for (genvar k = 0; k < ROWS; k++) begin : g_stage
        logic               src_valid;
        l2bh_pkg::words_t   src_words;
        l2bh_pkg::mix_ctl_t src_ctl;
        l2bh_pkg::words_t   words_next;

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_words = in_words;
            assign src_ctl   = in_ctl;
        end else begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_words = words_reg[k-1];
            assign src_ctl   = ctl_reg[k-1];
        end

        assign words_next = src_ctl.mix_en ? l2bh_pkg::mix_row(src_words, 4'(k)) : src_words;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= src_valid;
            end
            if (adv) begin
                words_reg[k] <= words_next;
                ctl_reg[k]   <= src_ctl;
            end
        end
    end

    assign out_valid = valid_reg[ROWS-1];
    assign out_words = words_reg[ROWS-1];
    assign out_ctl   = ctl_reg[ROWS-1];

endmodule

/* hdl/l2bh_front.sv */
// ----------------------------------------------------------------------------
// l2bh_front
// Byte assembly: packs key bytes into block words and issues mix requests.
// ----------------------------------------------------------------------------
`include "lookup2_byte_stream_hash_top_macros.svh"

module l2bh_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               adv,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               last_byte,
    input  l2bh_pkg::words_t   base_words,
    output logic               ent_valid,
    output l2bh_pkg::words_t   ent_words,
    output l2bh_pkg::mix_ctl_t ent_ctl
);

    logic [3:0]  pos_reg;
    logic [31:0] acc_a_reg;
    logic [31:0] acc_b_reg;
    logic [23:0] held_reg;
    logic [31:0] len_reg;

    logic [3:0]  pos_eff;
    logic [4:0]  lane_sh;
    logic [31:0] acc_a_next;
    logic [31:0] acc_b_next;
    logic [23:0] held_next;
    logic [31:0] len_next;
    logic [3:0]  pos_next;
    logic        block_done;

    logic               ent_valid_reg;
    l2bh_pkg::words_t   ent_words_reg;
    l2bh_pkg::mix_ctl_t ent_ctl_reg;
    l2bh_pkg::words_t   ent_words_next;
    l2bh_pkg::mix_ctl_t ent_ctl_next;

    // positions past the block end behave as the last position
    assign pos_eff    = (pos_reg > l2bh_pkg::BLOCK_LAST) ? l2bh_pkg::BLOCK_LAST : pos_reg;
    assign lane_sh    = {pos_eff[1:0], 3'b000};
    assign block_done = byte_present && (pos_eff == l2bh_pkg::BLOCK_LAST);

    always_comb begin
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        held_next  = held_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        if (byte_present) begin
            len_next = len_reg + 32'd1;
            pos_next = pos_eff + 4'd1;
            case (pos_eff[3:2])
                2'd0: begin
                    acc_a_next = acc_a_reg | (32'(data_byte) << lane_sh);
                end
                2'd1: begin
                    acc_b_next = acc_b_reg | (32'(data_byte) << lane_sh);
                end
                default: begin
                    if (!block_done) begin
                        held_next = held_reg | (24'(data_byte) << lane_sh);
                    end
                end
            endcase
        end
    end

    always_comb begin
        ent_ctl_next = '0;
        ent_ctl_next.fin = last_byte;
        if (block_done) begin
            ent_words_next.a      = base_words.a + acc_a_reg;
            ent_words_next.b      = base_words.b + acc_b_reg;
            ent_words_next.c      = base_words.c + {data_byte, held_reg};
            ent_ctl_next.mix_en   = 1'b1;
            ent_ctl_next.both     = last_byte;
            ent_ctl_next.tail.c   = len_next;
        end else begin
            // tail only: the base is picked up when the request leaves the mixer
            ent_words_next        = '0;
            ent_ctl_next.tail.a   = acc_a_next;
            ent_ctl_next.tail.b   = acc_b_next;
            ent_ctl_next.tail.c   = len_next + {held_next, 8'h00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            acc_a_reg     <= '0;
            acc_b_reg     <= '0;
            held_reg      <= '0;
            len_reg       <= '0;
            ent_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (last_byte || block_done) begin
                    pos_reg   <= '0;
                    acc_a_reg <= '0;
                    acc_b_reg <= '0;
                    held_reg  <= '0;
                    len_reg   <= last_byte ? '0 : len_next;
                end else begin
                    pos_reg   <= pos_next;
                    acc_a_reg <= acc_a_next;
                    acc_b_reg <= acc_b_next;
                    held_reg  <= held_next;
                    len_reg   <= len_next;
                end
            end
            if (adv) begin
                ent_valid_reg <= accept && (last_byte || block_done);
            end
        end
        if (adv) begin
            ent_words_reg <= ent_words_next;
            ent_ctl_reg   <= ent_ctl_next;
        end
    end

    assign ent_valid = ent_valid_reg;
    assign ent_words = ent_words_reg;
    assign ent_ctl   = ent_ctl_reg;

    `L2BH_ASSERT_IMP(ap_pos_range, aclk, aresetn, 1'b1, pos_reg <= l2bh_pkg::BLOCK_LAST)
    `L2BH_ASSERT_NXT(ap_last_clears, aclk, aresetn, accept && last_byte, (pos_reg == '0) && (len_reg == '0))

endmodule

/* hdl/lookup2_byte_stream_hash_top.sv */
// ----------------------------------------------------------------------------
// lookup2_byte_stream_hash_top
// Streaming lookup2-style 32-bit hash of byte keys.
// ----------------------------------------------------------------------------
// Takes one key byte per cycle while s_tready is high, and emits one 32-bit
// hash per key (an item with tlast set ends the key; a last item without a
// byte hashes the bytes so far, or the empty key). Each completed 12-byte block
// goes through a nine-stage mix pipeline, one round per stage; the end of a key
// then passes a combine register and a second nine-stage mix pipeline for the
// final mix, and the hash is then held in the output register. The mixed
// words of a block return to the byte assembly before the next block can complete.
// Input and output stall together only when a finished hash reaches the end
// of the pipe while the output register still holds one not yet taken.
// ----------------------------------------------------------------------------
`include "lookup2_byte_stream_hash_top_macros.svh"

module lookup2_byte_stream_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);

    logic adv;
    logic accept;

    logic               fr_valid;
    l2bh_pkg::words_t   fr_words;
    l2bh_pkg::mix_ctl_t fr_ctl;

    logic               m1_out_valid;
    l2bh_pkg::words_t   m1_out_words;
    l2bh_pkg::mix_ctl_t m1_out_ctl;

    logic               m2_out_valid;
    l2bh_pkg::words_t   m2_out_words;
    l2bh_pkg::mix_ctl_t m2_out_ctl;
    l2bh_pkg::mix_ctl_t m2_in_ctl;

    l2bh_pkg::words_t base_reg;
    l2bh_pkg::words_t comb_src;
    l2bh_pkg::words_t comb_words_next;
    l2bh_pkg::words_t comb_words_reg;
    logic             comb_valid_reg;
    logic             m1_adv_fin;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    assign adv    = !(m_valid_reg && !m_tready && m2_out_valid && m2_out_ctl.fin);
    assign accept = s_tvalid && adv;

    l2bh_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .adv          (adv),
        .data_byte    (s_tdata),
        .byte_present (s_tuser[0]),
        .last_byte    (s_tlast),
        .base_words   (base_reg),
        .ent_valid    (fr_valid),
        .ent_words    (fr_words),
        .ent_ctl      (fr_ctl)
    );

    l2bh_mix_pipe u_block_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_words  (fr_words),
        .in_ctl    (fr_ctl),
        .out_valid (m1_out_valid),
        .out_words (m1_out_words),
        .out_ctl   (m1_out_ctl)
    );

    // a tail-only request takes the key's running words here; requests leave in order
    assign comb_src          = m1_out_ctl.both ? m1_out_words : base_reg;
    assign comb_words_next.a = comb_src.a + m1_out_ctl.tail.a;
    assign comb_words_next.b = comb_src.b + m1_out_ctl.tail.b;
    assign comb_words_next.c = comb_src.c + m1_out_ctl.tail.c;
    assign m1_adv_fin        = adv && m1_out_valid && m1_out_ctl.fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= l2bh_pkg::INIT_WORDS;
            comb_valid_reg <= 1'b0;
        end else if (adv) begin
            comb_valid_reg <= m1_out_valid && m1_out_ctl.fin;
            if (m1_out_valid) begin
                base_reg <= m1_out_ctl.fin ? l2bh_pkg::INIT_WORDS : m1_out_words;
            end
        end
        if (adv) begin
            comb_words_reg <= comb_words_next;
        end
    end

    always_comb begin
        m2_in_ctl        = '0;
        m2_in_ctl.mix_en = 1'b1;
        m2_in_ctl.fin    = 1'b1;
    end

    l2bh_mix_pipe u_final_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (comb_valid_reg),
        .in_words  (comb_words_reg),
        .in_ctl    (m2_in_ctl),
        .out_valid (m2_out_valid),
        .out_words (m2_out_words),
        .out_ctl   (m2_out_ctl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && m2_out_valid && m2_out_ctl.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (adv && m2_out_valid && m2_out_ctl.fin) begin
            m_data_reg <= m2_out_words.c;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `L2BH_ASSERT_IMP(ap_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `L2BH_ASSERT_NXT(ap_final_combined, aclk, aresetn, m1_adv_fin, comb_valid_reg)
    `L2BH_ASSERT_IMP(ap_block_mixed, aclk, aresetn, m1_out_valid && !m1_out_ctl.fin, m1_out_ctl.mix_en)

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming lookup2-style byte key hash.
// ----------------------------------------------------------------------------
// Keys are streamed one byte per request, with random gaps on the input and
// random stalls on the output. A scoreboard class predicts the hash of every
// key from the accepted requests and compares each hash that leaves the block
// against the oldest prediction.
// ----------------------------------------------------------------------------

class hash_scoreboard;
    bit [31:0] word_a;
    bit [31:0] word_b;
    bit [31:0] word_c;
    bit [3:0]  block_pos;
    bit [23:0] pending_tail;
    bit [31:0] key_len;
    bit [31:0] expected_hashes[$];
    int        mismatch_count;

    function new();
        mismatch_count = 0;
        clear_key();
    endfunction

    function void clear_key();
        word_a       = l2bh_pkg::INIT_AB;
        word_b       = l2bh_pkg::INIT_AB;
        word_c       = l2bh_pkg::INIT_C;
        block_pos    = 4'd0;
        pending_tail = 24'd0;
        key_len      = 32'd0;
    endfunction

    function void scramble();
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] c;
        a = word_a;
        b = word_b;
        c = word_c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        word_a = a;
        word_b = b;
        word_c = c;
    endfunction

    // one accepted request on the input side
    function void note_request(bit [7:0] data_byte, bit byte_present, bit last_byte);
        bit [31:0] wide;
        wide = {24'd0, data_byte};
        if (byte_present) begin
            key_len = key_len + 32'd1;
            if (block_pos < 4) begin
                word_a = word_a + (wide << (8 * block_pos));
                block_pos = block_pos + 4'd1;
            end else if (block_pos < 8) begin
                word_b = word_b + (wide << (8 * (block_pos - 4)));
                block_pos = block_pos + 4'd1;
            end else if (block_pos < 11) begin
                pending_tail = pending_tail | 24'(wide << (8 * (block_pos - 8)));
                block_pos = block_pos + 4'd1;
            end else begin
                // block complete: bytes 8..11 go into c, then mix
                word_c = word_c + {data_byte, pending_tail};
                scramble();
                pending_tail = 24'd0;
                block_pos = 4'd0;
            end
        end
        if (last_byte) begin
            // tail bytes land one byte up, and the key length is added to c
            word_c = word_c + key_len + {pending_tail, 8'd0};
            scramble();
            expected_hashes.push_back(word_c);
            clear_key();
        end
    endfunction

    function void check_hash(bit [31:0] actual);
        bit [31:0] wanted;
        if (expected_hashes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected hash, expected none, actual %08h", $time, actual);
        end else begin
            wanted = expected_hashes.pop_front();
            if (wanted !== actual) begin
                mismatch_count++;
                $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                         $time, wanted, actual);
            end
        end
    endfunction
endclass

module testbench;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] byte_present
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] hash_value

    hash_scoreboard hash_sb;
    bit             steady_run;
    bit             add_noise;
    int             stall_left;
    int             bytes_sent;
    int             keys_sent;
    int             key_bytes;
    int             size_pick;

    lookup2_byte_stream_hash_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            hash_sb.note_request(s_tdata, s_tuser[0], s_tlast);
        if (aresetn && m_tvalid && m_tready)
            hash_sb.check_hash(m_tdata);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic send_request(bit [7:0] data_byte, bit byte_present, bit last_byte);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid   <= 1'b1;
        s_tdata    <= data_byte;
        s_tuser[0] <= byte_present;
        s_tlast    <= last_byte;
        do @(posedge aclk); while (!s_tready);
    endtask

    // fill_byte < 0 gives random bytes; separate_last ends with a request
    // that carries no byte
    task automatic send_key(int n_bytes, bit separate_last, int fill_byte);
        bit [7:0] value;
        for (int i = 0; i < n_bytes; i++) begin
            if (add_noise && $urandom_range(0, 19) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            value = (fill_byte < 0) ? 8'($urandom) : 8'(fill_byte);
            send_request(value, 1'b1, (i == n_bytes - 1) && !separate_last);
            bytes_sent++;
        end
        if (separate_last || n_bytes == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
        keys_sent++;
    endtask

    initial begin
        hash_sb    = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        steady_run = 1'b0;
        add_noise  = 1'b0;
        bytes_sent = 0;
        keys_sent  = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty key, an empty request, smallest and largest bytes,
        // a block completed by the last byte, tail bytes up to position 10
        send_key(0, 1'b1, -1);
        send_request(8'hff, 1'b0, 1'b0);
        send_key(1, 1'b0, 8'h00);
        send_key(12, 1'b0, 8'hff);
        send_key(11, 1'b1, -1);

        add_noise = 1'b1;
        while (bytes_sent < 460 || keys_sent < 20) begin
            if ($urandom_range(0, 7) == 0)
                steady_run = !steady_run;
            size_pick = $urandom_range(0, 19);
            if (size_pick < 10)
                key_bytes = $urandom_range(0, 13);
            else if (size_pick < 17)
                key_bytes = $urandom_range(14, 26);
            else
                key_bytes = $urandom_range(27, 50);
            send_key(key_bytes, $urandom_range(0, 2) == 0, -1);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        steady_run = 1'b0;

        while (hash_sb.expected_hashes.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (hash_sb.mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d hashes still outstanding", hash_sb.expected_hashes.size());
        $display("testbench: done, errors");
        $finish;
    end
endmodule
